// ===== rtl/acr_pkg.sv =====
`timescale 1ns / 1ps

package acr_pkg;

  // Cache geometry: bucket = ip mod BUCKETS, WAYS entries per bucket
  localparam int BUCKETS  = 16;
  localparam int WAYS     = 4;
  localparam int NENTRIES = BUCKETS * WAYS;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W    = $clog2(NENTRIES + 1);

  // Configuration register indexes
  localparam logic CFG_MY_IP  = 1'b0;
  localparam logic CFG_MY_MAC = 1'b1;

  localparam logic [31:0] MY_IP_RESET = 32'h0A00_020C;

  // Request types
  localparam logic [1:0] REQ_PACKET = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // ARP header codes
  localparam logic [15:0] HW_ETHERNET = 16'd1;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;

  // Opcodes of frames to send
  localparam logic [1:0] SEND_REQUEST = 2'd1;
  localparam logic [1:0] SEND_REPLY   = 2'd2;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  // Result status codes
  localparam logic [3:0] ST_BAD_HW  = 4'd0;
  localparam logic [3:0] ST_BAD_OP  = 4'd1;
  localparam logic [3:0] ST_NOT_OURS = 4'd2;
  localparam logic [3:0] ST_REPLIED = 4'd3;
  localparam logic [3:0] ST_LEARNED = 4'd4;
  localparam logic [3:0] ST_FULL    = 4'd5;
  localparam logic [3:0] ST_HIT     = 4'd6;
  localparam logic [3:0] ST_MISS    = 4'd7;
  localparam logic [3:0] ST_REMOVED = 4'd8;
  localparam logic [3:0] ST_ABSENT  = 4'd9;

  // One cache entry and one bucket row of the entry RAM
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

endpackage

// ===== rtl/arp_cache_responder_unit.sv =====
`timescale 1ns / 1ps

// ARP responder with a hashed IP-to-MAC cache. For each item (received ARP
// header, lookup or remove), at acceptance the item's bucket row is read
// from the entry RAM (synchronous read), and in the following cycle, with
// busy high, the ways are compared and the row is written back. The result
// shows on the out_ ports with out_strobe for one cycle right after that,
// while the next item can already be accepted; no new item is taken while
// busy is high. Every item gives exactly one result; the receiver cannot
// stall and must take each result as it comes.
// The cache starts empty after reset with no clearing pass.
module arp_cache_responder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata,
  // item input
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_opcode,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_target_ip,
  input  logic [31:0] in_query_ip,
  // result output
  output logic        out_strobe,
  output logic [3:0]  out_status,
  output logic        out_send_frame,
  output logic [1:0]  out_send_opcode,
  output logic [47:0] out_send_dest_mac,
  output logic [47:0] out_send_target_mac,
  output logic [31:0] out_send_target_ip,
  output logic [47:0] out_found_mac
);

  import acr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;

  // configuration; own MAC is filled into frames downstream, own IP is held
  logic [31:0] my_ip_r;

  // entry RAM, one row per bucket, plus valid flops and entry count
  row_t              mem [BUCKETS];
  row_t              rd_row_r;
  logic [WAYS-1:0]   valid_r [BUCKETS];
  logic [CNT_W-1:0]  count_r;

  // latched item
  logic [1:0]   req_r;
  logic [15:0]  hw_r;
  logic [15:0]  op_r;
  logic [31:0]  sip_r;
  logic [47:0]  smac_r;
  logic [31:0]  tip_r;
  logic [31:0]  key_r;
  logic [BKT_W-1:0] bkt_r;

  // result registers
  logic        out_strobe_r;
  logic [3:0]  status_r;
  logic        send_frame_r;
  logic [1:0]  send_opcode_r;
  logic [47:0] send_dest_mac_r;
  logic [47:0] send_target_mac_r;
  logic [31:0] send_target_ip_r;
  logic [47:0] found_mac_r;

  logic        accept;
  logic [31:0] in_key;
  logic [BKT_W-1:0] in_bkt;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign in_key = (in_req_type == REQ_PACKET) ? in_sender_ip : in_query_ip;
  assign in_bkt = BKT_W'(in_key % BUCKETS);

  // way compare on the fetched row
  logic [WAYS-1:0]  row_valid;
  logic [WAYS-1:0]  hit_vec;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic             hit_any;
  logic             free_any;

  always_comb begin
    row_valid = valid_r[bkt_r];
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row_valid[w] && (rd_row_r[w].ip == key_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!row_valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
    hit_any  = |hit_vec;
    free_any = ~&row_valid;
  end

  // item decode, row update and result
  logic             mem_we;
  row_t             wr_row;
  logic [WAYS-1:0]  valid_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [3:0]  status_nxt;
  logic        send_frame_nxt;
  logic [1:0]  send_opcode_nxt;
  logic [47:0] send_dest_mac_nxt;
  logic [47:0] send_target_mac_nxt;
  logic [31:0] send_target_ip_nxt;
  logic [47:0] found_mac_nxt;

  always_comb begin
    mem_we              = 1'b0;
    wr_row              = rd_row_r;
    valid_nxt           = row_valid;
    count_nxt           = count_r;
    status_nxt          = ST_BAD_OP;
    send_frame_nxt      = 1'b0;
    send_opcode_nxt     = '0;
    send_dest_mac_nxt   = '0;
    send_target_mac_nxt = '0;
    send_target_ip_nxt  = '0;
    found_mac_nxt       = '0;
    case (req_r)
      REQ_PACKET: begin
        if (hw_r != HW_ETHERNET) begin
          status_nxt = ST_BAD_HW;
        end else if (op_r == OP_REQUEST) begin
          if (tip_r == my_ip_r) begin
            status_nxt          = ST_REPLIED;
            send_frame_nxt      = 1'b1;
            send_opcode_nxt     = SEND_REPLY;
            send_dest_mac_nxt   = smac_r;
            send_target_mac_nxt = smac_r;
            send_target_ip_nxt  = sip_r;
          end else begin
            status_nxt = ST_NOT_OURS;
          end
        end else if (op_r == OP_REPLY) begin
          // learn: refresh a known binding, else take the first free way
          if (hit_any) begin
            wr_row[hit_way].mac = smac_r;
            mem_we              = 1'b1;
            status_nxt          = ST_LEARNED;
          end else if (free_any) begin
            wr_row[free_way].ip  = sip_r;
            wr_row[free_way].mac = smac_r;
            valid_nxt[free_way]  = 1'b1;
            count_nxt            = count_r + 1'b1;
            mem_we               = 1'b1;
            status_nxt           = ST_LEARNED;
          end else begin
            status_nxt = ST_FULL;
          end
        end else begin
          status_nxt = ST_BAD_OP;
        end
      end
      REQ_LOOKUP: begin
        if (hit_any) begin
          status_nxt    = ST_HIT;
          found_mac_nxt = rd_row_r[hit_way].mac;
        end else begin
          status_nxt          = ST_MISS;
          send_frame_nxt      = 1'b1;
          send_opcode_nxt     = SEND_REQUEST;
          send_dest_mac_nxt   = MAC_BCAST;
          send_target_ip_nxt  = key_r;
        end
      end
      REQ_REMOVE: begin
        if (hit_any) begin
          valid_nxt[hit_way] = 1'b0;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          status_nxt = ST_REMOVED;
        end else begin
          status_nxt = ST_ABSENT;
        end
      end
      default: begin
        status_nxt = ST_BAD_OP;
      end
    endcase
  end

  // entry RAM: read at acceptance, write back in the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row_r <= mem[in_bkt];
    end
    if (state_r == S_EXEC && mem_we) begin
      mem[bkt_r] <= wr_row;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      hw_r   <= in_hw_type;
      op_r   <= in_opcode;
      sip_r  <= in_sender_ip;
      smac_r <= in_sender_mac;
      tip_r  <= in_target_ip;
      key_r  <= in_key;
      bkt_r  <= in_bkt;
    end
  end

  // sequencer, valid flops, count, configuration and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      count_r      <= '0;
      my_ip_r      <= MY_IP_RESET;
      for (int b = 0; b < BUCKETS; b++) begin
        valid_r[b] <= '0;
      end
    end else begin
      if (cfg_we && cfg_index == CFG_MY_IP) begin
        my_ip_r <= cfg_wdata[31:0];
      end
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r          <= S_IDLE;
          out_strobe_r     <= 1'b1;
          valid_r[bkt_r]   <= valid_nxt;
          count_r          <= count_nxt;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      status_r          <= status_nxt;
      send_frame_r      <= send_frame_nxt;
      send_opcode_r     <= send_opcode_nxt;
      send_dest_mac_r   <= send_dest_mac_nxt;
      send_target_mac_r <= send_target_mac_nxt;
      send_target_ip_r  <= send_target_ip_nxt;
      found_mac_r       <= found_mac_nxt;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_status          = status_r;
  assign out_send_frame      = send_frame_r;
  assign out_send_opcode     = send_opcode_r;
  assign out_send_dest_mac   = send_dest_mac_r;
  assign out_send_target_mac = send_target_mac_r;
  assign out_send_target_ip  = send_target_ip_r;
  assign out_found_mac       = found_mac_r;

  // checks
  logic [NENTRIES-1:0] valid_flat;

  always_comb begin
    for (int b = 0; b < BUCKETS; b++) begin
      valid_flat[b*WAYS +: WAYS] = valid_r[b];
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_flat) == int'(count_r))
    else $error("entry count out of step with valid bits");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not enter execute");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("execute cycle gave no result");

  a_no_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_send_frame) |->
      (out_send_target_ip == '0 && out_send_dest_mac == '0))
    else $error("frame fields set without a frame");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import acr_pkg::*;

  localparam int         CYCLE_LIMIT = 100000;
  localparam int         POOL_SIZE   = 20;
  // request type the block must ignore
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] hw_type;
    logic [15:0] opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } arp_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        send_frame;
    logic [1:0]  send_opcode;
    logic [47:0] dest_mac;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [47:0] found_mac;
  } arp_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [47:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = '0;
  logic [15:0] in_hw_type = '0;
  logic [15:0] in_opcode = '0;
  logic [31:0] in_sender_ip = '0;
  logic [47:0] in_sender_mac = '0;
  logic [31:0] in_target_ip = '0;
  logic [31:0] in_query_ip = '0;
  logic        out_strobe;
  logic [3:0]  out_status;
  logic        out_send_frame;
  logic [1:0]  out_send_opcode;
  logic [47:0] out_send_dest_mac;
  logic [47:0] out_send_target_mac;
  logic [31:0] out_send_target_ip;
  logic [47:0] out_found_mac;

  arp_cache_responder_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_hw_type          (in_hw_type),
    .in_opcode           (in_opcode),
    .in_sender_ip        (in_sender_ip),
    .in_sender_mac       (in_sender_mac),
    .in_target_ip        (in_target_ip),
    .in_query_ip         (in_query_ip),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_send_frame      (out_send_frame),
    .out_send_opcode     (out_send_opcode),
    .out_send_dest_mac   (out_send_dest_mac),
    .out_send_target_mac (out_send_target_mac),
    .out_send_target_ip  (out_send_target_ip),
    .out_found_mac       (out_found_mac)
  );

  always #10 clk = ~clk;

  // Shadow copy of the cache and the own-address registers
  bit           cache_valid [NENTRIES];
  logic [31:0]  cache_ip    [NENTRIES];
  logic [47:0]  cache_mac   [NENTRIES];
  logic [31:0]  own_ip  = MY_IP_RESET;
  logic [47:0]  own_mac = '0;

  arp_outcome_t outcome_q[$];
  logic [31:0]  ip_pool [POOL_SIZE];
  bit           gaps_on = 1'b1;
  int           fail_cnt = 0;
  int           cycle_cnt = 0;

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // first entry of the bucket that holds ip
  function automatic int row_base(logic [31:0] ip);
    return int'(ip % BUCKETS) * WAYS;
  endfunction

  // way holding ip within its bucket, -1 if not cached
  function automatic int way_of(logic [31:0] ip);
    int base;
    base = row_base(ip);
    for (int w = 0; w < WAYS; w++) begin
      if (cache_valid[base + w] && cache_ip[base + w] == ip) return w;
    end
    return -1;
  endfunction

  // Expected result of one item; updates the shadow cache
  function automatic arp_outcome_t arp_outcome(arp_item_t it);
    arp_outcome_t r;
    int base;
    int hit_w;
    int free_w;
    r = '0;
    case (it.req_type)
      REQ_PACKET: begin
        if (it.hw_type != HW_ETHERNET) begin
          r.status = ST_BAD_HW;
        end else if (it.opcode != OP_REQUEST && it.opcode != OP_REPLY) begin
          r.status = ST_BAD_OP;
        end else if (it.opcode == OP_REQUEST) begin
          if (it.target_ip == own_ip) begin
            r.status      = ST_REPLIED;
            r.send_frame  = 1'b1;
            r.send_opcode = SEND_REPLY;
            r.dest_mac    = it.sender_mac;
            r.target_mac  = it.sender_mac;
            r.target_ip   = it.sender_ip;
          end else begin
            r.status = ST_NOT_OURS;
          end
        end else begin
          // reply: refresh a known binding or take the first free way
          base  = row_base(it.sender_ip);
          hit_w = way_of(it.sender_ip);
          if (hit_w >= 0) begin
            cache_mac[base + hit_w] = it.sender_mac;
            r.status = ST_LEARNED;
          end else begin
            free_w = -1;
            for (int w = 0; w < WAYS; w++) begin
              if (!cache_valid[base + w] && free_w < 0) free_w = w;
            end
            if (free_w >= 0) begin
              cache_valid[base + free_w] = 1'b1;
              cache_ip[base + free_w]    = it.sender_ip;
              cache_mac[base + free_w]   = it.sender_mac;
              r.status = ST_LEARNED;
            end else begin
              r.status = ST_FULL;
            end
          end
        end
      end
      REQ_LOOKUP: begin
        hit_w = way_of(it.query_ip);
        if (hit_w >= 0) begin
          r.status    = ST_HIT;
          r.found_mac = cache_mac[row_base(it.query_ip) + hit_w];
        end else begin
          r.status      = ST_MISS;
          r.send_frame  = 1'b1;
          r.send_opcode = SEND_REQUEST;
          r.dest_mac    = MAC_BCAST;
          r.target_ip   = it.query_ip;
        end
      end
      REQ_REMOVE: begin
        hit_w = way_of(it.query_ip);
        if (hit_w >= 0) begin
          cache_valid[row_base(it.query_ip) + hit_w] = 1'b0;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: r.status = ST_BAD_OP;
    endcase
    return r;
  endfunction

  // Received ARP header; the query field is don't-care
  function automatic arp_item_t arp_packet(logic [15:0] hw, logic [15:0] op,
                                           logic [31:0] sip, logic [47:0] smac,
                                           logic [31:0] tip);
    arp_item_t it;
    it = {REQ_PACKET, hw, op, sip, smac, tip, 32'($urandom)};
    return it;
  endfunction

  // Lookup, remove or unused type; header fields are don't-care
  function automatic arp_item_t cache_request(logic [1:0] rt, logic [31:0] ip);
    arp_item_t it;
    it = {rt, 16'($urandom), 16'($urandom), 32'($urandom), rand_mac(),
          32'($urandom), ip};
    return it;
  endfunction

  // mostly addresses from a few crowded buckets, now and then any address
  function automatic logic [31:0] pool_ip();
    if ($urandom_range(99) < 85) return ip_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic arp_item_t random_arp_item();
    arp_item_t it;
    int pick;
    it = {2'($urandom), 16'($urandom), 16'($urandom), 32'($urandom), rand_mac(),
          32'($urandom), 32'($urandom)};
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.req_type  = REQ_PACKET;
      it.hw_type   = HW_ETHERNET;
      it.opcode    = OP_REPLY;
      it.sender_ip = pool_ip();
    end else if (pick < 55) begin
      it.req_type = REQ_LOOKUP;
      it.query_ip = pool_ip();
    end else if (pick < 70) begin
      it.req_type = REQ_REMOVE;
      it.query_ip = pool_ip();
    end else if (pick < 82) begin
      it.req_type = REQ_PACKET;
      it.hw_type  = HW_ETHERNET;
      it.opcode   = OP_REQUEST;
      if ($urandom_range(1)) it.target_ip = own_ip;
    end else if (pick < 94) begin
      // malformed header
      it.req_type = REQ_PACKET;
      if ($urandom_range(1)) it.hw_type = HW_ETHERNET;
    end
    return it;
  endfunction

  // Present one item, hold it until accepted, record its expected result
  task automatic send_item(input arp_item_t it);
    if (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= it.req_type;
    in_hw_type    <= it.hw_type;
    in_opcode     <= it.opcode;
    in_sender_ip  <= it.sender_ip;
    in_sender_mac <= it.sender_mac;
    in_target_ip  <= it.target_ip;
    in_query_ip   <= it.query_ip;
    do @(posedge clk); while (busy);
    outcome_q.push_back(arp_outcome(it));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  // Both registers, written only with nothing in flight
  task automatic set_config(input logic [47:0] ip_word, input logic [47:0] mac_word);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MY_IP;
    cfg_wdata <= ip_word;
    @(posedge clk);
    own_ip     = ip_word[31:0];
    cfg_index <= CFG_MY_MAC;
    cfg_wdata <= mac_word;
    @(posedge clk);
    own_mac    = mac_word;
    cfg_we    <= 1'b0;
  endtask

  // hardware type is checked ahead of the opcode
  task automatic test_header_checks();
    send_item(arp_packet(16'h0000, OP_REQUEST, $urandom, rand_mac(), MY_IP_RESET));
    send_item(arp_packet(16'hFFFF, 16'h0000, $urandom, rand_mac(), MY_IP_RESET));
    send_item(arp_packet(HW_ETHERNET, 16'h0000, $urandom, rand_mac(), MY_IP_RESET));
    send_item(arp_packet(HW_ETHERNET, 16'hFFFF, $urandom, rand_mac(), MY_IP_RESET));
  endtask

  task automatic test_request_reply();
    send_item(arp_packet(HW_ETHERNET, OP_REQUEST, 32'hFFFF_FFFF, MAC_BCAST, MY_IP_RESET));
    send_item(arp_packet(HW_ETHERNET, OP_REQUEST, 32'h0, 48'h0, MY_IP_RESET));
    send_item(arp_packet(HW_ETHERNET, OP_REQUEST, $urandom, rand_mac(), MY_IP_RESET ^ 1));
  endtask

  // IP zero is an ordinary address; a refresh rewrites only its own MAC
  task automatic test_learn_lookup();
    send_item(arp_packet(HW_ETHERNET, OP_REPLY, 32'h0, rand_mac(), $urandom));
    send_item(cache_request(REQ_LOOKUP, 32'h0));
    send_item(arp_packet(HW_ETHERNET, OP_REPLY, 32'h0, rand_mac(), $urandom));
    send_item(cache_request(REQ_LOOKUP, 32'h0));
    send_item(arp_packet(HW_ETHERNET, OP_REPLY, 32'hFFFF_FFFF, MAC_BCAST, $urandom));
    send_item(cache_request(REQ_LOOKUP, 32'hFFFF_FFFF));
    send_item(cache_request(REQ_LOOKUP, 32'h1234_5678));
  endtask

  // bucket zero already holds IP zero; three more fill it
  task automatic test_bucket_overflow();
    for (int i = 1; i < WAYS; i++) begin
      send_item(arp_packet(HW_ETHERNET, OP_REPLY, 32'(i * BUCKETS), rand_mac(), $urandom));
    end
    send_item(arp_packet(HW_ETHERNET, OP_REPLY, 32'(WAYS * BUCKETS), rand_mac(), $urandom));
    send_item(cache_request(REQ_LOOKUP, 32'(WAYS * BUCKETS)));
    send_item(cache_request(REQ_REMOVE, 32'(BUCKETS)));
    send_item(cache_request(REQ_REMOVE, 32'(BUCKETS)));
    send_item(arp_packet(HW_ETHERNET, OP_REPLY, 32'(WAYS * BUCKETS), rand_mac(), $urandom));
  endtask

  // the unused type must not learn even with a valid reply header
  task automatic test_unused_request();
    arp_item_t it;
    it = arp_packet(HW_ETHERNET, OP_REPLY, 32'h0BAD_0001, rand_mac(), $urandom);
    it.req_type = REQ_UNUSED;
    send_item(it);
    send_item(cache_request(REQ_LOOKUP, 32'h0BAD_0001));
  endtask

  task automatic test_random_traffic(input int n_items, input bit with_gaps);
    logic [3:0] rows [4];
    for (int b = 0; b < 4; b++) rows[b] = 4'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = {28'($urandom), rows[i % 4]};
    gaps_on = with_gaps;
    repeat (n_items) send_item(random_arp_item());
    gaps_on = 1'b1;
  endtask

  // own-address extremes, with junk above bit 31 of the IP write
  task automatic test_config_sweep();
    set_config({16'hFFFF, 32'h0}, MAC_BCAST);
    test_random_traffic(110, 1'b1);
    set_config({16'h0, 32'hFFFF_FFFF}, 48'h0);
    test_random_traffic(110, 1'b0);
    set_config(rand_mac(), rand_mac());
    test_random_traffic(110, 1'b1);
    set_config({16'($urandom), MY_IP_RESET}, rand_mac());
    test_random_traffic(120, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_header_checks();
    test_request_reply();
    test_learn_lookup();
    test_bucket_overflow();
    test_unused_request();
    test_config_sweep();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // every strobed result against the oldest outstanding item
  always @(posedge clk) begin
    arp_outcome_t want;
    if (out_strobe === 1'b1) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none got status %0d",
                 $time, out_status);
        fail_cnt++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", 48'(want.status), 48'(out_status));
        check_field("send_frame", 48'(want.send_frame), 48'(out_send_frame));
        check_field("send_opcode", 48'(want.send_opcode), 48'(out_send_opcode));
        check_field("send_dest_mac", want.dest_mac, out_send_dest_mac);
        check_field("send_target_mac", want.target_mac, out_send_target_mac);
        check_field("send_target_ip", 48'(want.target_ip), 48'(out_send_target_ip));
        check_field("found_mac", want.found_mac, out_found_mac);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
